[sv/tcop_pkg.sv]
// ----------------------------------------------------------------------------
// tcop_pkg
// Shared types and constants for the dual-clock offset pinner.
// ----------------------------------------------------------------------------
package tcop_pkg;

    localparam int STAMP_W = 63;
    localparam int OFF_W   = 64;

    localparam logic ACT_STAMP = 1'b0;
    localparam logic ACT_FORCE = 1'b1;

    localparam logic KIND_VALID   = 1'b0;
    localparam logic KIND_INVALID = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [STAMP_W-1:0]   stamp;
        logic                 clock_kind;
    } item_t;

endpackage

[sv/tcop_front.sv]
// ----------------------------------------------------------------------------
// tcop_front
// Accepts input transactions into a short two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module tcop_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  tcop_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output tcop_pkg::item_t q_item
);
    tcop_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end
endmodule

[sv/tcop_div.sv]
// ----------------------------------------------------------------------------
// tcop_div
// Restoring divider, one quotient bit per cycle, 64-bit saturated quotient.
// ----------------------------------------------------------------------------
module tcop_div #(
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH:0]   num,
    input  logic [63:0]            den,
    output logic                   done,
    output logic [63:0]            quo
);
    localparam int SH    = 2 * FRAC_BITS;
    localparam int STEPS = SH + 64;
    localparam int NW    = COUNT_WIDTH + 1;
    localparam int IW    = $clog2(STEPS + 1);
    localparam int NIW   = $clog2(NW);

    logic [IW-1:0] i_reg;
    logic          busy_reg, sat_reg;
    logic [63:0]   rem_reg, q_reg;
    logic [NW-1:0] n_reg;
    logic [63:0]   den_reg;
    logic          bit_in, sub;
    logic [64:0]   shifted;
    logic [IW-1:0] idx;

    always_comb begin
        idx    = i_reg - IW'(1);
        bit_in = 1'b0;
        if (idx >= IW'(SH) && (idx - IW'(SH)) < IW'(NW)) begin
            bit_in = n_reg[NIW'(idx - IW'(SH))];
        end
        shifted = {rem_reg, bit_in};
        sub     = shifted[64] || (shifted[63:0] >= den_reg);
    end

    assign done = busy_reg && (i_reg == IW'(1));
    assign quo  = (sat_reg || q_reg[63]) ? '1 : {q_reg[62:0], sub};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            i_reg    <= IW'(STEPS);
            n_reg    <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= sub ? shifted[63:0] - den_reg : shifted[63:0];
            if (q_reg[63]) sat_reg <= 1'b1;
            q_reg <= {q_reg[62:0], sub};
            i_reg <= i_reg - IW'(1);
            if (i_reg == IW'(1)) busy_reg <= 1'b0;
        end
    end
endmodule

[sv/tcop_back.sv]
// ----------------------------------------------------------------------------
// tcop_back
// Executes queued transactions: run tracking, bracketing and forced pins.
// ----------------------------------------------------------------------------
module tcop_back #(
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  tcop_pkg::item_t           q_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_estimated_now,
    output logic                      m_offset_known,
    output logic signed [63:0]        m_offset,
    output logic [62:0]               m_error_bound,
    output logic                      m_error_unknown,
    output logic                      m_rate_fault
);
    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_OUT} state_t;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    state_t state_reg;
    tcop_pkg::item_t it_reg;
    logic [1:0]  cur_reg;
    logic        have_reg, unk_reg;
    logic [63:0] boff_reg;
    logic [62:0] berr_reg;
    logic [62:0] hi_reg [2];
    logic [62:0] lo_reg [2];
    logic [COUNT_WIDTH-1:0] cnt_reg [2];
    logic [63:0] a_reg, b_reg, base_reg;
    logic [62:0] ec_reg;
    logic        est_reg, fault_reg;

    logic        k, o, c, oc;
    logic [63:0] a_n, b_n, mag, off, d1, d2, err;
    logic [63:0] s0, s1, ssum;
    logic [COUNT_WIDTH:0] total;
    logic        div_start, div_done;
    logic [63:0] quo, p, sum;
    logic signed [63:0] basev;

    assign k  = q_item.clock_kind;
    assign o  = ~k;
    assign c  = cur_reg[0];
    assign oc = ~c;

    always_comb begin
        a_n  = {1'b0, hi_reg[k]} + {1'b0, q_item.stamp};
        b_n  = {1'b0, lo_reg[o]} + {1'b0, hi_reg[o]};
        d1   = (q_item.stamp >= hi_reg[k]) ? {1'b0, q_item.stamp - hi_reg[k]}
                                           : {1'b0, hi_reg[k] - q_item.stamp};
        d2   = {1'b0, hi_reg[o] - lo_reg[o]};
        s0   = {1'b0, hi_reg[0] - lo_reg[0]};
        s1   = {1'b0, hi_reg[1] - lo_reg[1]};
        ssum = s0 + s1;
        total = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        mag  = ((a_reg >= b_reg) ? a_reg - b_reg : b_reg - a_reg) >> 1;
        off  = (a_reg >= b_reg) ? mag : 64'd0 - mag;
        if (it_reg.clock_kind == tcop_pkg::KIND_INVALID) off = 64'd0 - off;
        err  = {1'b0, ec_reg};
        basev = $signed({1'b0, lo_reg[c]}) - $signed({1'b0, hi_reg[oc]});
        p    = quo[63] ? 64'h7FFF_FFFF_FFFF_FFFF : quo;
        sum  = base_reg + p;
        if (!base_reg[63] && sum[63]) sum = 64'h7FFF_FFFF_FFFF_FFFF;
        if (c == tcop_pkg::KIND_INVALID) sum = 64'd0 - sum;
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_estimated_now = est_reg;
    assign m_offset_known  = have_reg;
    assign m_offset        = $signed(boff_reg);
    assign m_error_bound   = berr_reg;
    assign m_error_unknown = unk_reg;
    assign m_rate_fault    = fault_reg;
    assign div_start = (state_reg == ST_IDLE) && q_valid
                       && q_item.action == tcop_pkg::ACT_FORCE && !have_reg
                       && cnt_reg[1] != '0 && total > (COUNT_WIDTH+1)'(2) && ssum != '0;

    tcop_div #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(total - (COUNT_WIDTH+1)'(2)), .den(ssum),
        .done(div_done), .quo(quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= 2'd2;
            have_reg  <= 1'b0;
            unk_reg   <= 1'b0;
            boff_reg  <= '0;
            berr_reg  <= '0;
            hi_reg[0] <= '0; hi_reg[1] <= '0;
            lo_reg[0] <= '0; lo_reg[1] <= '0;
            cnt_reg[0] <= '0; cnt_reg[1] <= '0;
            est_reg   <= 1'b0;
            fault_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        it_reg    <= q_item;
                        est_reg   <= 1'b0;
                        fault_reg <= 1'b0;
                        state_reg <= ST_OUT;
                        if (q_item.action == tcop_pkg::ACT_STAMP) begin
                            if ({1'b0, k} == cur_reg) begin
                                if (cnt_reg[k] != CMAX) begin
                                    cnt_reg[k] <= cnt_reg[k] + COUNT_WIDTH'(1);
                                end
                                if (q_item.stamp > hi_reg[k]) hi_reg[k] <= q_item.stamp;
                                if (q_item.stamp < lo_reg[k]) lo_reg[k] <= q_item.stamp;
                            end else begin
                                cur_reg    <= {1'b0, k};
                                cnt_reg[k] <= COUNT_WIDTH'(1);
                                lo_reg[k]  <= q_item.stamp;
                                hi_reg[k]  <= q_item.stamp;
                                if (lo_reg[k] != '0 && lo_reg[o] != '0) begin
                                    a_reg  <= a_n;
                                    b_reg  <= b_n;
                                    ec_reg <= 63'(((d1 >= d2) ? d1 - d2 : d2 - d1) >> 1);
                                    state_reg <= ST_CALC;
                                end
                            end
                        end else if (!have_reg) begin
                            if (cnt_reg[1] == '0) begin
                                have_reg <= 1'b1;
                                boff_reg <= '0;
                                berr_reg <= '0;
                                unk_reg  <= 1'b0;
                            end else if (total > (COUNT_WIDTH+1)'(2)) begin
                                if (ssum == '0) fault_reg <= 1'b1;
                                else begin
                                    base_reg  <= basev;
                                    state_reg <= ST_DIV;
                                end
                            end else begin
                                berr_reg <= '0;
                                unk_reg  <= 1'b1;
                                boff_reg <= (c == tcop_pkg::KIND_INVALID) ? 64'd0 - basev : basev;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    est_reg <= 1'b1;
                    if (!have_reg || err[62:0] < berr_reg) begin
                        boff_reg <= off;
                        berr_reg <= err[62:0];
                        have_reg <= 1'b1;
                        unk_reg  <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        boff_reg  <= sum;
                        berr_reg  <= quo[63:1];
                        unk_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[sv/two_clock_offset_pinner_top.sv]
// ----------------------------------------------------------------------------
// two_clock_offset_pinner_top
// Estimates valid-minus-invalid clock offset from tagged timestamps.
// ----------------------------------------------------------------------------
// Flow: a stamp goes from ST_IDLE to ST_OUT, and may pass through ST_CALC when it
// starts a new run; a force with a rate pin waits in ST_DIV for the bit-serial divider.
// Throughput: one transaction at a time in the back end, a two-entry queue
// in front. Synchronous active-low reset clears all runs and the estimate.
module two_clock_offset_pinner_top #(
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [62:0]        s_stamp,
    input  logic               s_clock_kind,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_estimated_now,
    output logic               m_offset_known,
    output logic signed [63:0] m_offset,
    output logic [62:0]        m_error_bound,
    output logic               m_error_unknown,
    output logic               m_rate_fault
);
    tcop_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    assign in_item = '{action: s_action, stamp: s_stamp, clock_kind: s_clock_kind};

    tcop_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    tcop_back #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_estimated_now(m_estimated_now), .m_offset_known(m_offset_known),
        .m_offset(m_offset), .m_error_bound(m_error_bound),
        .m_error_unknown(m_error_unknown), .m_rate_fault(m_rate_fault)
    );
endmodule
